// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// File: rtl/crst_pkg.sv
package crst_pkg;

    localparam int COORD_W = 32;            // Q16.16 coordinate
    localparam int SEG_W   = 6;             // segment count register
    localparam int T_W     = 17;            // t, t^2, t^3 in Q1.16 (0..65536)
    localparam int W_W     = 21;            // basis weight, signed
    localparam int MUL_A_W = 33;            // multiplier operand A, signed
    localparam int PROD_W  = MUL_A_W + W_W; // product and sums, signed
    localparam int SH_W    = PROD_W - 17;   // sum after the floor shift by 17
    localparam int DIV_CNT_W = 5;

    localparam logic [SEG_W-1:0]     SEG_RESET    = 6'd16;
    localparam logic [SEG_W-1:0]     MAX_SEGMENTS = 6'd63;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST     = 5'd16;   // 17 quotient bits
    localparam logic [3:0]           MAC_LAST     = 4'd12;   // 3 axes x 4 points
    localparam logic signed [W_W-1:0] TWO_Q16     = 21'sd131072;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_T2   = 7'b0000100,
        ST_T3   = 7'b0001000,
        ST_WGT  = 7'b0010000,
        ST_MAC  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    // floor(s / 2^17), then clamp to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat_q16(
        input logic signed [PROD_W-1:0] s
    );
        logic [SH_W-1:0] sh;
        logic [SH_W-COORD_W:0] top;
        sh  = s[PROD_W-1:17];
        top = sh[SH_W-1:COORD_W-1];
        if (top == '0 || top == '1)
            return sh[COORD_W-1:0];
        else if (sh[SH_W-1])
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

// File: rtl/catmull_rom_segment_tessellator.sv
// Operation: a point that only fills the window is taken in the idle state; a point that
//   completes a window runs the divide, then for each of its n+1 curve points (n = effective
//   segment count, 16 by default) the T2, T3, WGT, MAC and OUT states, sharing the one 33x21
//   multiplier (t*t, t2*t, then 12 products); a curve point waiting on out_ready holds the sequencer
//   in OUT, and no new control point is taken until the run's last curve point is registered.
// Reset: asynchronous, active low; clears point count, sequencer, output valid; segments 16.
module catmull_rom_segment_tessellator
    import crst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // control point items
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      first_point,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    // curve point items
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] curve_x,
    output logic signed [COORD_W-1:0] curve_y,
    output logic signed [COORD_W-1:0] curve_z,
    output logic                      last_of_run,
    // segment count register
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [SEG_W-1:0]          segment_count
);

    // ------------------------------------------------------------------
    // Sequencer per completing point:
    //   DIV : restoring divide 65536 / n, one quotient bit a cycle. t for
    //         step j is then tracked as t += q, rem += r, wrap on rem >= n.
    //   T2  : t*t             (shared multiplier)
    //   T3  : t2 = (t*t)>>16, then t2*t
    //   WGT : t3 = (t2*t)>>16, Catmull-Rom basis weights w0..w3
    //   MAC : 12 products p_k*w_k, one a cycle, each registered, then summed per axis
    //   OUT : floor-shift and saturate into the output register
    // The curve is sum_k p_k*w_k with
    //   w0 = -t + 2t2 - t3, w1 = 2*65536 - 5t2 + 3t3,
    //   w2 = t + 4t2 - 3t3, w3 = t3 - t2,
    // which is the exact expansion of the usual coefficient form.
    // ------------------------------------------------------------------

    state_t state_reg, state_next;

    point_t held_reg [3];
    point_t held_next [3];
    logic [1:0] held_cnt_reg, held_cnt_next;
    point_t new_reg, new_next;

    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [SEG_W-1:0] n_reg, n_next;

    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [T_W-1:0]       div_q_reg, div_q_next;
    logic [SEG_W-1:0]     div_r_reg, div_r_next;

    logic [SEG_W-1:0] j_reg, j_next;
    logic [T_W-1:0]   t_reg, t_next;
    logic [SEG_W-1:0] r_reg, r_next;
    logic [T_W-1:0]   t2_reg, t2_next;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [W_W-1:0]    w_reg [4];
    logic signed [W_W-1:0]    w_next [4];
    logic [3:0]               mac_cnt_reg, mac_cnt_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] sum_reg [3];
    logic signed [PROD_W-1:0] sum_next [3];

    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next;
    logic signed [COORD_W-1:0] cy_reg, cy_next;
    logic signed [COORD_W-1:0] cz_reg, cz_next;
    logic                      last_reg, last_next;

    // handshake
    logic       in_acc;
    logic [1:0] eff_cnt;
    logic [SEG_W-1:0] n_clamp;

    // divider step
    logic             div_bit;
    logic [SEG_W:0]   div_shift;
    logic [SEG_W:0]   div_diff;
    logic             div_ge;

    // t advance
    logic [SEG_W:0]   r_sum;
    logic             r_wrap;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [W_W-1:0]     mul_b;
    logic [T_W-1:0]            t_hi;     // (t*t)>>16 or (t2*t)>>16
    logic [1:0]                mac_axis, mac_k;
    logic [3:0]                mac_d;
    point_t                    sel_pt;
    logic signed [COORD_W-1:0] sel_coord;

    // weights
    logic signed [W_W-1:0] tw, t2w, t3w;

    logic out_free;
    point_t in_pt;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign eff_cnt   = first_point ? 2'd0 : held_cnt_reg;
    assign in_pt     = '{x: point_x, y: point_y, z: point_z};

    assign out_valid   = out_valid_reg;
    assign curve_x     = cx_reg;
    assign curve_y     = cy_reg;
    assign curve_z     = cz_reg;
    assign last_of_run = last_reg;

    // zero means one, anything above the limit means the limit
    always_comb
    begin
        if (seg_reg == '0)
            n_clamp = SEG_W'(1);
        else if (seg_reg > MAX_SEGMENTS)
            n_clamp = MAX_SEGMENTS;
        else
            n_clamp = seg_reg;
    end

    // dividend is 65536: only its top bit (first step) is set
    assign div_bit   = (div_cnt_reg == '0);
    assign div_shift = {div_r_reg, div_bit};
    assign div_diff  = div_shift - {1'b0, n_reg};
    assign div_ge    = (div_shift >= {1'b0, n_reg});

    assign r_sum  = {1'b0, r_reg} + {1'b0, div_r_reg};
    assign r_wrap = (r_sum >= {1'b0, n_reg});

    assign t_hi     = prod_reg[2*T_W-2:T_W-1];
    assign mac_axis = mac_cnt_reg[3:2];
    assign mac_k    = mac_cnt_reg[1:0];
    assign mac_d    = mac_cnt_reg - 4'd1;

    // operand point for the current product
    always_comb
    begin
        unique case (mac_k)
            2'd0: sel_pt = held_reg[0];
            2'd1: sel_pt = held_reg[1];
            2'd2: sel_pt = held_reg[2];
            2'd3: sel_pt = new_reg;
        endcase
        case (mac_axis)
            2'd0:    sel_coord = sel_pt.x;
            2'd1:    sel_coord = sel_pt.y;
            default: sel_coord = sel_pt.z;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        priority if (state_reg == ST_T2)
        begin
            mul_a = signed'({{(MUL_A_W-T_W){1'b0}}, t_reg});
            mul_b = signed'({{(W_W-T_W){1'b0}}, t_reg});
        end
        else if (state_reg == ST_T3)
        begin
            mul_a = signed'({{(MUL_A_W-T_W){1'b0}}, t_hi});
            mul_b = signed'({{(W_W-T_W){1'b0}}, t_reg});
        end
        else
        begin
            mul_a = {sel_coord[COORD_W-1], sel_coord};
            mul_b = w_reg[mac_k];
        end
    end

    assign tw  = signed'({{(W_W-T_W){1'b0}}, t_reg});
    assign t2w = signed'({{(W_W-T_W){1'b0}}, t2_reg});
    assign t3w = signed'({{(W_W-T_W){1'b0}}, t_hi});

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        new_next      = new_reg;
        seg_next      = seg_reg;
        n_next        = n_reg;
        div_cnt_next  = div_cnt_reg;
        div_q_next    = div_q_reg;
        div_r_next    = div_r_reg;
        j_next        = j_reg;
        t_next        = t_reg;
        r_next        = r_reg;
        t2_next       = t2_reg;
        prod_next     = prod_reg;
        w_next        = w_reg;
        mac_cnt_next  = mac_cnt_reg;
        acc_next      = acc_reg;
        sum_next      = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        last_next     = last_reg;

        if (cfg_valid && cfg_ready)
            seg_next = segment_count;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (eff_cnt != 2'd3)
                    begin
                        // still filling the window
                        for (int i = 0; i < 3; i++)
                        begin
                            if (eff_cnt == 2'(i))
                                held_next[i] = in_pt;
                        end
                        held_cnt_next = eff_cnt + 2'd1;
                    end
                    else
                    begin
                        new_next     = in_pt;
                        n_next       = n_clamp;
                        div_cnt_next = '0;
                        div_q_next   = '0;
                        div_r_next   = '0;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                div_q_next = {div_q_reg[T_W-2:0], div_ge};
                div_r_next = div_ge ? div_diff[SEG_W-1:0] : div_shift[SEG_W-1:0];
                if (div_cnt_reg == DIV_LAST)
                begin
                    j_next     = '0;
                    t_next     = '0;
                    r_next     = '0;
                    state_next = ST_T2;
                end
                else
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_T2:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_T3;
            end
            ST_T3:
            begin
                t2_next    = t_hi;
                prod_next  = mul_a * mul_b;
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                w_next[0]    = (t2w <<< 1) - tw - t3w;
                w_next[1]    = TWO_Q16 - (t2w <<< 2) - t2w + (t3w <<< 1) + t3w;
                w_next[2]    = tw + (t2w <<< 2) - (t3w <<< 1) - t3w;
                w_next[3]    = t3w - t2w;
                mac_cnt_next = '0;
                state_next   = ST_MAC;
            end
            ST_MAC:
            begin
                prod_next = mul_a * mul_b;
                // sum the product issued in the previous cycle
                if (mac_cnt_reg != '0)
                begin
                    if (mac_d[1:0] == 2'd0)
                        acc_next = prod_reg;
                    else if (mac_d[1:0] == 2'd3)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (mac_d[3:2] == 2'(i))
                                sum_next[i] = acc_reg + prod_reg;
                        end
                    end
                    else
                        acc_next = acc_reg + prod_reg;
                end
                if (mac_cnt_reg == MAC_LAST)
                    state_next = ST_OUT;
                else
                    mac_cnt_next = mac_cnt_reg + 4'd1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cx_next        = sat_q16(sum_reg[0]);
                    cy_next        = sat_q16(sum_reg[1]);
                    cz_next        = sat_q16(sum_reg[2]);
                    last_next      = (j_reg == n_reg);
                    if (j_reg == n_reg)
                    begin
                        // slide the window by one point
                        held_next[0] = held_reg[1];
                        held_next[1] = held_reg[2];
                        held_next[2] = new_reg;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + SEG_W'(1);
                        t_next     = T_W'(t_reg + div_q_reg + T_W'(r_wrap));
                        r_next     = r_wrap ? SEG_W'(r_sum - {1'b0, n_reg}) : r_sum[SEG_W-1:0];
                        state_next = ST_T2;
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_cnt_reg  <= '0;
            seg_reg       <= SEG_RESET;
            div_cnt_reg   <= '0;
            mac_cnt_reg   <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_cnt_reg  <= held_cnt_next;
            seg_reg       <= seg_next;
            div_cnt_reg   <= div_cnt_next;
            mac_cnt_reg   <= mac_cnt_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        held_reg  <= held_next;
        new_reg   <= new_next;
        n_reg     <= n_next;
        div_q_reg <= div_q_next;
        div_r_reg <= div_r_next;
        t_reg     <= t_next;
        r_reg     <= r_next;
        t2_reg    <= t2_next;
        prod_reg  <= prod_next;
        w_reg     <= w_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        last_reg  <= last_next;
    end

endmodule

// File: rtl/crst_checker.sv
`include "assert_macros.svh"

module crst_checker
    import crst_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [COORD_W-1:0] curve_x,
    input logic signed [COORD_W-1:0] curve_y,
    input logic signed [COORD_W-1:0] curve_z,
    input logic                      last_of_run
);

    // a stalled curve point holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(curve_x) && $stable(curve_y) && $stable(curve_z) && $stable(last_of_run))

    // while a run is still pending the block takes no new control point
    `ASSERT_IMPLY(a_busy_mid_run, clk, rst_n, out_valid && !last_of_run, !in_ready)

    // once ready again, anything left waiting is the run's last point
    `ASSERT_IMPLY(a_idle_last, clk, rst_n, in_ready && out_valid, last_of_run)

    // a curve point never appears the cycle after a control point is taken
    `ASSERT_IMPLY(a_no_instant_out, clk, rst_n, $rose(out_valid), !$past(in_valid && in_ready))

endmodule

bind catmull_rom_segment_tessellator crst_checker u_crst_checker (.*);

// File: tb/tb_catmull_rom_segment_tessellator.sv
module tb_catmull_rom_segment_tessellator;

    import crst_pkg::*;

    // row count that means "work the curve points out", not typed in
    localparam int PREDICT     = -1;
    // wait for a taken item to work through the block; leave a margin on top
    localparam int SETTLE      = 40;
    // cycles with no item moving on any channel before the run is given up
    localparam int QUIET_LIMIT = 4000;
    localparam int N_PHASES    = 8;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // one expected curve point
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } curve_pt_t;

    // one row of the directed table; exp_n of PREDICT leaves the points to the
    // tessellation below, otherwise exp_n copies of (ex, ey, ez) are expected
    typedef struct {
        bit               fp;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        int               exp_n;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COORD_W-1:0] ez;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      first_point = 1'b0;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic signed [COORD_W-1:0] point_z = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic signed [COORD_W-1:0] curve_z;
    logic                      last_of_run;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [SEG_W-1:0]          segment_count = '0;

    // expectation attached to the item currently on the input channel
    int                 row_expect_n = PREDICT;
    logic [COORD_W-1:0] row_expect_x = '0;
    logic [COORD_W-1:0] row_expect_y = '0;
    logic [COORD_W-1:0] row_expect_z = '0;

    // own copy of the block state: control point window and segment count
    longint           win_x [3];
    longint           win_y [3];
    longint           win_z [3];
    int               win_fill = 0;
    logic [SEG_W-1:0] seg_reg  = SEG_RESET;

    curve_pt_t curve_expect [$];
    dir_row_t  plan [$];
    int        errors = 0;
    int        quiet  = 0;

    int phase_seg   [N_PHASES] = '{1, 0, 63, 3, 8, 2, 12, 16};
    int phase_items [N_PHASES] = '{60, 40, 6, 60, 45, 55, 40, 20};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    catmull_rom_segment_tessellator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_point   (first_point),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .curve_x       (curve_x),
        .curve_y       (curve_y),
        .curve_z       (curve_z),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .segment_count (segment_count)
    );

    // ------------------------------------------------------------------
    // Curve arithmetic
    // ------------------------------------------------------------------

    // One axis of the uniform Catmull-Rom blend. Every term is exact in 64 bits
    // (worst case around 2^51), the sum is floored by 2^17 (the 0.5 and the
    // Q16.16 scaling together) and then clamped to 32 bits.
    function automatic logic signed [COORD_W-1:0] curve_axis(
        input longint p0, input longint p1, input longint p2, input longint p3,
        input longint t, input longint t2, input longint t3
    );
        longint e1;
        longint e2;
        longint e3;
        longint acc;
        e1  = p2 - p0;
        e2  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        e3  = -p0 + 3 * p1 - 3 * p2 + p3;
        acc = 2 * p1 * 65536 + e1 * t + e2 * t2 + e3 * t3;
        acc = acc >>> 17;
        if (acc > Q_MAX)
            acc = Q_MAX;
        if (acc < Q_MIN)
            acc = Q_MIN;
        return acc[COORD_W-1:0];
    endfunction

    // Feed one control point into the window. With a full window this works
    // out the n+1 curve points between the middle two and slides the window;
    // keep = 0 updates the state only (row expectation typed in instead).
    task automatic tessellate_point(
        input bit fp, input logic signed [COORD_W-1:0] nx,
        input logic signed [COORD_W-1:0] ny, input logic signed [COORD_W-1:0] nz,
        input bit keep
    );
        int        n;
        longint    t;
        longint    t2;
        longint    t3;
        curve_pt_t pt;
        if (fp)
            win_fill = 0;
        if (win_fill < 3)
        begin
            // still filling: store and emit nothing
            win_x[win_fill] = nx;
            win_y[win_fill] = ny;
            win_z[win_fill] = nz;
            win_fill++;
            return;
        end
        // zero subdivisions behaves as one
        n = (seg_reg == '0) ? 1 : int'(seg_reg);
        if (n > int'(MAX_SEGMENTS))
            n = int'(MAX_SEGMENTS);
        for (int j = 0; j <= n; j++)
        begin
            t  = (longint'(j) * 65536) / n;
            t2 = (t * t) >>> 16;
            t3 = (t2 * t) >>> 16;
            pt.x    = curve_axis(win_x[0], win_x[1], win_x[2], nx, t, t2, t3);
            pt.y    = curve_axis(win_y[0], win_y[1], win_y[2], ny, t, t2, t3);
            pt.z    = curve_axis(win_z[0], win_z[1], win_z[2], nz, t, t2, t3);
            pt.last = (j == n);
            if (keep)
                curve_expect = {curve_expect, pt};
        end
        win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = nx;
        win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = ny;
        win_z[0] = win_z[1]; win_z[1] = win_z[2]; win_z[2] = nz;
    endtask

    // ------------------------------------------------------------------
    // Monitor: all three channels sampled at the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : monitor
        curve_pt_t want;
        curve_pt_t typed;
        if (rst_n)
        begin
            // result side first; a new item can never produce a point this cycle
            if (out_valid && out_ready)
            begin
                if (curve_expect.size() == 0)
                begin
                    $error("curve point with none expected: x=%0d y=%0d z=%0d last=%0b",
                           curve_x, curve_y, curve_z, last_of_run);
                    errors++;
                end
                else
                begin
                    want = curve_expect.pop_front();
                    if (curve_x !== want.x)
                    begin
                        $error("curve_x: expected %0d, got %0d", want.x, curve_x);
                        errors++;
                    end
                    if (curve_y !== want.y)
                    begin
                        $error("curve_y: expected %0d, got %0d", want.y, curve_y);
                        errors++;
                    end
                    if (curve_z !== want.z)
                    begin
                        $error("curve_z: expected %0d, got %0d", want.z, curve_z);
                        errors++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                        errors++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (row_expect_n == PREDICT)
                    tessellate_point(first_point, point_x, point_y, point_z, 1'b1);
                else
                begin
                    // typed row: the window still has to move on
                    tessellate_point(first_point, point_x, point_y, point_z, 1'b0);
                    for (int k = 0; k < row_expect_n; k++)
                    begin
                        typed.x    = row_expect_x;
                        typed.y    = row_expect_y;
                        typed.z    = row_expect_z;
                        typed.last = (k == row_expect_n - 1);
                        curve_expect = {curve_expect, typed};
                    end
                end
            end

            if (cfg_valid && cfg_ready)
                seg_reg = segment_count;
        end
    end

    // Watchdog: a long spell with no item moving anywhere means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet == QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 90);
    endfunction

    // full-range patterns, small values near the origin, the extremes and
    // mid-sized values, so that curves both stay in range and saturate
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
            7:
                case ($urandom_range(0, 3))
                    0:       return 32'h7fff_ffff;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            default:    return $urandom_range(0, 32'h1fff_ffff) - 32'h1000_0000;
        endcase
    endfunction

    task automatic add_row(
        input bit fp, input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z, input int exp_n, input logic [COORD_W-1:0] ex,
        input logic [COORD_W-1:0] ey, input logic [COORD_W-1:0] ez
    );
        dir_row_t r;
        r.fp = fp; r.x = x; r.y = y; r.z = z;
        r.exp_n = exp_n; r.ex = ex; r.ey = ey; r.ez = ez;
        plan = {plan, r};
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back items never drop valid.
    task automatic send_point(
        input bit fp, input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z, input int exp_n, input logic [COORD_W-1:0] ex,
        input logic [COORD_W-1:0] ey, input logic [COORD_W-1:0] ez, input int gap
    );
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        first_point  = fp;
        point_x      = x;
        point_y      = y;
        point_z      = z;
        row_expect_n = exp_n;
        row_expect_x = ex;
        row_expect_y = ey;
        row_expect_z = ez;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (curve_expect.size() != 0)
            @(negedge clk);
    endtask

    // only with the block idle: drained, then a filling item given time to land
    task automatic write_segments(input logic [SEG_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        segment_count = v;
        cfg_valid     = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: bursts of ready broken by stalls of random length
    // ------------------------------------------------------------------

    initial
    begin : receiver
        int g;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            out_ready = 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            g = idle_len();
            if (g > 0)
            begin
                out_ready = 1'b0;
                repeat (g) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    initial
    begin : sender
        bit steady;
        int n_items;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, run at the reset segment count of 16 (17 points each).
        // Filling rows and flat windows are typed in; the rest are worked out.
        add_row(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, '0);
        add_row(1'b0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 0, '0, '0, '0);
        // restart while still filling: the two points above are dropped
        add_row(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, '0, '0, '0);
        add_row(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, '0, '0, '0);
        add_row(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, '0, '0, '0);
        // four equal points at the extremes: every curve point is that point
        add_row(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                17, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        // swinging between the extremes drives the blend into saturation
        add_row(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, PREDICT, '0, '0, '0);
        add_row(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, PREDICT, '0, '0, '0);
        add_row(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_fffe, PREDICT, '0, '0, '0);
        add_row(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, PREDICT, '0, '0, '0);
        // restart from a full window, then a straight line
        add_row(1'b1, 32'h0001_0000, 32'hffff_0000, 32'h0000_0000, 0, '0, '0, '0);
        add_row(1'b0, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000, 0, '0, '0, '0);
        add_row(1'b0, 32'h0003_0000, 32'hfffd_0000, 32'h0001_0000, 0, '0, '0, '0);
        add_row(1'b0, 32'h0004_0000, 32'hfffc_0000, 32'h0001_8000, PREDICT, '0, '0, '0);
        add_row(1'b0, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, PREDICT, '0, '0, '0);
        add_row(1'b0, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, PREDICT, '0, '0, '0);
        add_row(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, PREDICT, '0, '0, '0);
        // all-zero curve
        add_row(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, '0);
        add_row(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, '0);
        add_row(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, '0);
        add_row(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 17, '0, '0, '0);
        add_row(1'b0, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, PREDICT, '0, '0, '0);

        foreach (plan[i])
            send_point(plan[i].fp, plan[i].x, plan[i].y, plan[i].z, plan[i].exp_n,
                       plan[i].ex, plan[i].ey, plan[i].ez, idle_len());

        // Random phases, one segment count each: 1, 0 (acts as 1), 63 (the
        // ceiling, with only 6 items as each gives 64 curve points), then mid
        // values and a random one, finishing back at 16.
        phase_seg[6] = $urandom_range(4, 12);
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_segments(phase_seg[p][SEG_W-1:0]);
            steady  = ($urandom_range(0, 2) == 0);
            n_items = phase_items[p];
            for (int k = 0; k < n_items; k++)
            begin
                // in even phases, hold off mid-phase until every curve point is out
                if (p % 2 == 0 && k == n_items / 2)
                    wait_drained();
                // restarts are rare so that most items complete a window
                send_point($urandom_range(0, 14) == 0, pick_coord(), pick_coord(),
                           pick_coord(), PREDICT, '0, '0, '0,
                           steady ? 0 : idle_len());
            end
        end

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
